// ----- hdl/bcba_pkg.sv -----
// ----------------------------------------------------------------------------
// bcba_pkg
// Shared types and constants of the first-fit bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bcba_pkg;

    localparam int MAX_BLOCKS = 4096; // blocks held by the bitmap
    localparam int WORD_BITS = 8;    // allocation bits per memory word
    localparam int POS_W     = 13;   // block position width
    localparam int WIDX_W    = 10;   // word index width (POS_W - 3)

    localparam logic [2:0] OP_ALLOC     = 3'd0;
    localparam logic [2:0] OP_FREE      = 3'd1;
    localparam logic [2:0] OP_QUERY     = 3'd2;
    localparam logic [2:0] OP_SET_ALLOC = 3'd3;
    localparam logic [2:0] OP_SET_FREE  = 3'd4;

    localparam logic [1:0] ADDR_BLK_LIMIT = 2'd0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_SCAN,
        ST_MOD,
        ST_QRY,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/bitmap_contiguous_block_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_contiguous_block_allocator
// First-fit allocator over a bitmap held in a word memory, 8 blocks a word.
// ----------------------------------------------------------------------------
// channel   direction  handshake                     payload
// request   in         start & !busy                 i_op i_block i_count
// result    out        o_done, one cycle             o_ok o_run_base
//                                                    o_is_allocated o_free_count
// config    in         psel & penable & pwrite       paddr pwdata (prdata)
//
// Every stage reads or rewrites one 8-bit memory word a cycle. Allocate
// scans words until a run fits or the block limit is passed, then rewrites
// the run's words; free rewrites its run's words, set rewrites one word and
// query reads one; a request that needs no memory access (index out of range,
// zero-count free, zero or oversize allocate, unknown op) goes straight to the result.
// After reset and after each block limit write a clearing pass zeroes
// MAX_BLOCKS/8 words (512), one a cycle, with busy high.
// Results cannot be stalled: o_done is a single-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_contiguous_block_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_op,
    input  wire logic [11:0] i_block,
    input  wire logic [12:0] i_count,
    output logic             o_done,
    output logic             o_ok,
    output logic [11:0]      o_run_base,
    output logic             o_is_allocated,
    output logic [12:0]      o_free_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bcba_pkg::*;

    localparam int DEPTH = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CLRW  = (DEPTH < 1024) ? DEPTH : 1024;
    localparam logic [POS_W-1:0] NB_CAP = POS_W'((MAX_BLOCKS > 8191) ? 8191 : MAX_BLOCKS);
    localparam logic [WIDX_W-1:0] CLR_LAST = WIDX_W'(CLRW - 1);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata;

    t_state r_state, n_state, r_after, n_after;
    logic [POS_W-1:0]  r_num, r_total, n_total;
    logic [WIDX_W-1:0] r_word, n_word;
    logic [POS_W-1:0]  r_len, n_len, r_run, n_run, r_first, n_first;
    logic [POS_W-1:0]  r_lo, n_lo, r_hi, n_hi;
    logic              r_set, n_set;
    logic [2:0]        r_bit, n_bit;
    logic              r_ok, n_ok, r_isa, n_isa;
    logic [11:0]       r_sblk, n_sblk;

    logic [POS_W-1:0]  nb;
    logic              cfg_wr, accept;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata, mod_mask, mod_new;
    logic [3:0]        mod_delta;
    logic [POS_W:0]    free_end;

    assign nb     = (r_num > NB_CAP) ? NB_CAP : r_num;
    assign cfg_wr = psel & penable & pwrite & (paddr == ADDR_BLK_LIMIT);
    assign accept = start & ~busy;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BLK_LIMIT) ? {19'd0, r_num} : 32'd0;

    // Masks and changed-bit count for the word under modification.
    always_comb begin
        logic [POS_W-1:0] pos;
        mod_mask  = '0;
        mod_delta = '0;
        for (int k = 0; k < WORD_BITS; k++) begin
            pos = {r_word, 3'(k)};
            mod_mask[k] = (pos >= r_lo) && (pos < r_hi);
        end
        mod_new = r_set ? (rdata | mod_mask) : (rdata & ~mod_mask);
        for (int k = 0; k < WORD_BITS; k++) begin
            mod_delta = mod_delta + 4'(mod_mask[k] & (rdata[k] ^ r_set));
        end
    end

    assign free_end = {2'b00, i_block} + {1'b0, i_count};

    // Next state and datapath registers.
    always_comb begin
        logic [POS_W-1:0] pos, run, first;
        logic             found, stop;
        n_state = r_state;
        n_after = r_after;
        n_total = r_total;
        n_word  = r_word;
        n_len   = r_len;
        n_run   = r_run;
        n_first = r_first;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_set   = r_set;
        n_bit   = r_bit;
        n_ok    = r_ok;
        n_isa   = r_isa;
        n_sblk  = r_sblk;
        run     = r_run;
        first   = r_first;
        found   = 1'b0;
        stop    = 1'b0;
        pos     = '0;
        unique case (r_state)
            ST_CLEAR: begin
                n_word = r_word + WIDX_W'(1);
                if (r_word == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_ok   = 1'b1;
                    n_isa  = 1'b0;
                    n_sblk = '0;
                    n_state = ST_RESP;
                    unique case (i_op)
                        OP_ALLOC: begin
                            if (i_count != '0 && i_count <= nb) begin
                                n_len   = i_count;
                                n_run   = '0;
                                n_first = '0;
                                n_word  = '0;
                                n_after = ST_SCAN;
                                n_state = ST_RD;
                            end else begin
                                n_ok = 1'b0;
                            end
                        end
                        OP_FREE: begin
                            if ({1'b0, i_block} < nb && i_count != '0) begin
                                n_lo    = {1'b0, i_block};
                                n_hi    = (free_end > {1'b0, nb}) ? nb : free_end[POS_W-1:0];
                                n_set   = 1'b0;
                                n_word  = {1'b0, i_block[11:3]};
                                n_after = ST_MOD;
                                n_state = ST_RD;
                            end
                        end
                        OP_QUERY: begin
                            if ({1'b0, i_block} < nb) begin
                                n_bit   = i_block[2:0];
                                n_word  = {1'b0, i_block[11:3]};
                                n_after = ST_QRY;
                                n_state = ST_RD;
                            end
                        end
                        OP_SET_ALLOC, OP_SET_FREE: begin
                            if ({1'b0, i_block} < nb) begin
                                n_lo    = {1'b0, i_block};
                                n_hi    = {1'b0, i_block} + POS_W'(1);
                                n_set   = (i_op == OP_SET_ALLOC);
                                n_word  = {1'b0, i_block[11:3]};
                                n_after = ST_MOD;
                                n_state = ST_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD: begin
                n_state = r_after;
            end
            ST_SCAN: begin
                for (int k = 0; k < WORD_BITS; k++) begin
                    pos = {r_word, 3'(k)};
                    if (!found && !stop) begin
                        if (pos >= nb) begin
                            stop = 1'b1;
                        end else if (!rdata[k]) begin
                            if (run == '0) first = pos;
                            run = run + POS_W'(1);
                            if (run >= r_len) found = 1'b1;
                        end else begin
                            run = '0;
                        end
                    end
                end
                n_run   = run;
                n_first = first;
                n_word  = r_word + WIDX_W'(1);
                if (found) begin
                    n_lo    = first;
                    n_hi    = first + r_len;
                    n_set   = 1'b1;
                    n_sblk  = first[11:0];
                    n_word  = first[POS_W-1:3];
                    n_after = ST_MOD;
                    n_state = ST_RD;
                end else if (stop) begin
                    n_ok    = 1'b0;
                    n_state = ST_RESP;
                end
            end
            ST_MOD: begin
                n_total = r_set ? r_total + POS_W'(mod_delta) : r_total - POS_W'(mod_delta);
                n_word  = r_word + WIDX_W'(1);
                if (r_word == WIDX_W'((r_hi - POS_W'(1)) >> 3)) begin
                    n_state = ST_RESP;
                end
            end
            ST_QRY: begin
                n_isa   = rdata[r_bit];
                n_state = ST_RESP;
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs and memory controls.
    always_comb begin
        busy      = (r_state != ST_IDLE);
        o_done    = (r_state == ST_RESP);
        mem_raddr = AW'((r_state == ST_RD) ? r_word : r_word + WIDX_W'(1));
        mem_waddr = AW'(r_word);
        mem_we    = 1'b0;
        mem_wdata = '0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_MOD: begin
                mem_we    = 1'b1;
                mem_wdata = mod_new;
            end
            default: begin
            end
        endcase
    end

    assign o_ok           = r_ok;
    assign o_run_base     = r_sblk;
    assign o_is_allocated = r_isa;
    assign o_free_count   = (nb > r_total) ? nb - r_total : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_after <= ST_IDLE;
            r_num   <= 13'd4096;
            r_total <= '0;
            r_word  <= '0;
        end else if (cfg_wr) begin
            // restart the clearing pass on every block limit write
            r_num   <= pwdata[POS_W-1:0];
            r_total <= '0;
            r_word  <= '0;
            r_state <= ST_CLEAR;
            r_after <= ST_IDLE;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_total <= n_total;
            r_word  <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_run   <= n_run;
        r_first <= n_first;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_set   <= n_set;
        r_bit   <= n_bit;
        r_ok    <= n_ok;
        r_isa   <= n_isa;
        r_sblk  <= n_sblk;
    end

endmodule

`default_nettype wire

// ----- tb/bcba_checker.sv -----
// ----------------------------------------------------------------------------
// bcba_checker
// Watches the request and result words of the block allocator, keeps a
// shadow bitmap, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bcba_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [2:0]  i_op,
    input  wire logic [11:0] i_block,
    input  wire logic [12:0] i_count,
    input  wire logic        i_done,
    input  wire logic        i_ok,
    input  wire logic [11:0] i_run_base,
    input  wire logic        i_is_allocated,
    input  wire logic [12:0] i_free_count,
    input  wire logic        i_cfg_wr,
    input  wire logic [12:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending,
    output int               o_results
);
    import bcba_pkg::*;

    typedef struct packed {
        logic        ok;
        logic [11:0] run_base;
        logic        is_allocated;
        logic [12:0] free_count;
    } t_result;

    logic        shadow_bits [4096];
    int          shadow_total;
    int          shadow_blocks;
    t_result     result_fifo [$];

    function automatic t_result predict_request(logic [2:0] op, logic [11:0] blk,
                                                logic [12:0] cnt);
        t_result r;
        int nb, run, first, last, s;
        bit found;
        nb = (shadow_blocks > 4096) ? 4096 : shadow_blocks;
        r = '0;
        r.ok = 1'b1;
        case (op)
            OP_ALLOC: begin
                run = 0; first = 0; found = 0; s = 0;
                if (cnt != 0) begin
                    for (int i = 0; i < nb && !found; i++) begin
                        if (!shadow_bits[i]) begin
                            if (run == 0) first = i;
                            run++;
                            if (run >= cnt) begin
                                found = 1; s = first;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                end
                if (!found) begin
                    r.ok = 1'b0;
                end else begin
                    for (int i = 0; i < cnt; i++) shadow_bits[s + i] = 1'b1;
                    shadow_total += cnt;
                    r.run_base = s[11:0];
                end
            end
            OP_FREE: begin
                last = int'(blk) + int'(cnt);
                if (last > nb) last = nb;
                for (int i = blk; i < last; i++) begin
                    if (shadow_bits[i]) begin
                        shadow_bits[i] = 1'b0;
                        shadow_total--;
                    end
                end
            end
            OP_QUERY: if (blk < nb) r.is_allocated = shadow_bits[blk];
            OP_SET_ALLOC: if (blk < nb && !shadow_bits[blk]) begin
                shadow_bits[blk] = 1'b1;
                shadow_total++;
            end
            OP_SET_FREE: if (blk < nb && shadow_bits[blk]) begin
                shadow_bits[blk] = 1'b0;
                shadow_total--;
            end
            default: ;
        endcase
        r.free_count = (nb > shadow_total) ? 13'(nb - shadow_total) : '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r, got;
        if (!i_rst_n) begin
            foreach (shadow_bits[i]) shadow_bits[i] = 1'b0;
            shadow_total  = 0;
            shadow_blocks = 4096;
            o_errors      = 0;
            o_results     = 0;
            result_fifo.delete();
        end else begin
            // results come before the new request of the same edge
            if (i_done) begin
                got = {i_ok, i_run_base, i_is_allocated, i_free_count};
                o_results++;
                if (result_fifo.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result word %h", got);
                end else begin
                    exp_r = result_fifo.pop_front();
                    if (got !== exp_r) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: ok %b/%b base %0d/%0d isa %b/%b free %0d/%0d",
                                     exp_r.ok, got.ok, exp_r.run_base, got.run_base,
                                     exp_r.is_allocated, got.is_allocated,
                                     exp_r.free_count, got.free_count);
                    end
                end
            end
            if (i_start && !i_busy)
                result_fifo.push_back(predict_request(i_op, i_block, i_count));
            if (i_cfg_wr) begin
                shadow_blocks = int'(i_cfg_data);
                foreach (shadow_bits[i]) shadow_bits[i] = 1'b0;
                shadow_total = 0;
            end
        end
        o_pending = result_fifo.size();
    end
endmodule

// ----- tb/bitmap_contiguous_block_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// bitmap_contiguous_block_allocator_tb
// Drives directed and random requests and register writes into the block
// allocator; the checker predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bitmap_contiguous_block_allocator_tb;
    import bcba_pkg::*;

    // op codes with no defined operation
    localparam logic [2:0] OP_RSVD_LO = 3'd5;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_op;
    logic [11:0] i_block;
    logic [12:0] i_count;
    logic        o_done, o_ok, o_is_allocated;
    logic [11:0] o_run_base;
    logic [12:0] o_free_count;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    int          errors, pending, results;
    int          idle_cycles;
    int          accepted;
    logic        cfg_wr;

    bitmap_contiguous_block_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_block(i_block), .i_count(i_count),
        .o_done(o_done), .o_ok(o_ok), .o_run_base(o_run_base),
        .o_is_allocated(o_is_allocated), .o_free_count(o_free_count),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    assign cfg_wr = psel && penable && pwrite && pready && paddr == ADDR_BLK_LIMIT;

    bcba_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_op(i_op), .i_block(i_block), .i_count(i_count),
        .i_done(o_done), .i_ok(o_ok), .i_run_base(o_run_base),
        .i_is_allocated(o_is_allocated), .i_free_count(o_free_count),
        .i_cfg_wr(cfg_wr), .i_cfg_data(pwdata[12:0]),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog: cycles with no request, result or block limit write accepted
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || cfg_wr) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 40000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_request(logic [2:0] op, logic [11:0] blk, logic [12:0] cnt);
        int gap;
        gap = $urandom_range(0, 11);
        repeat (gap) @(negedge i_clk);
        i_op = op; i_block = blk; i_count = cnt;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        accepted++;
        @(negedge i_clk);
        start = 1'b0;
        i_op = 3'($urandom); i_block = 12'($urandom); i_count = 13'($urandom);
    endtask

    task automatic drain_results();
        while (pending != 0) @(negedge i_clk);
        // a request in flight cannot exist here, but let the block settle
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_blocks(logic [12:0] nb);
        drain_results();
        psel = 1'b1; pwrite = 1'b1; paddr = ADDR_BLK_LIMIT; pwdata = {19'd0, nb};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; pwdata = $urandom;
    endtask

    function automatic logic [12:0] rand_count(int nb);
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) return 13'($urandom_range(0, 12));
        if (k < 90) return 13'($urandom_range(0, (nb < 64) ? 64 : nb / 4));
        return 13'($urandom);
    endfunction

    function automatic logic [11:0] rand_block(int nb);
        if ($urandom_range(0, 9) < 8 && nb > 0) return 12'($urandom_range(0, nb - 1));
        return 12'($urandom);
    endfunction

    initial begin
        int nb;
        int settings [6];
        settings = '{4096, 0, 1, 37, 200, 8191};
        i_rst_n = 1'b0; start = 1'b0;
        i_op = '0; i_block = '0; i_count = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        accepted = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes and every op at reset size
        send_request(OP_ALLOC, 12'd0, 13'd0);
        send_request(OP_ALLOC, 12'd0, 13'd1);
        send_request(OP_ALLOC, 12'd0, 13'd7);
        send_request(OP_QUERY, 12'd0, 13'd0);
        send_request(OP_QUERY, 12'd4095, 13'd0);
        send_request(OP_SET_ALLOC, 12'd4095, 13'd0);
        send_request(OP_SET_ALLOC, 12'd4095, 13'd0);
        send_request(OP_QUERY, 12'd4095, 13'd0);
        send_request(OP_SET_FREE, 12'd4095, 13'd0);
        send_request(OP_SET_FREE, 12'd4095, 13'd0);
        send_request(OP_FREE, 12'd2, 13'd3);
        send_request(OP_ALLOC, 12'd0, 13'd2);
        send_request(OP_ALLOC, 12'd0, 13'd4096);
        send_request(OP_ALLOC, 12'd0, 13'd8191);
        send_request(OP_FREE, 12'd0, 13'd8191);
        send_request(OP_ALLOC, 12'd0, 13'd4096);
        send_request(OP_QUERY, 12'd2048, 13'd0);
        send_request(OP_RSVD_LO, 12'hfff, 13'h1fff);
        send_request(OP_RSVD_HI, 12'd0, 13'd0);
        send_request(OP_FREE, 12'd4000, 13'd4096);
        send_request(OP_FREE, 12'd0, 13'd0);
        write_blocks(13'd10);
        send_request(OP_SET_ALLOC, 12'd10, 13'd0);
        send_request(OP_QUERY, 12'd10, 13'd0);
        send_request(OP_ALLOC, 12'd0, 13'd11);

        for (int p = 0; p < 6; p++) begin
            nb = settings[p];
            write_blocks(13'(nb));
            if (nb > 4096) nb = 4096;
            for (int n = 0; n < 250; n++) begin
                int k;
                logic [2:0] op;
                k = $urandom_range(0, 99);
                if (k < 40) op = OP_ALLOC;
                else if (k < 60) op = OP_FREE;
                else if (k < 75) op = OP_QUERY;
                else if (k < 85) op = OP_SET_ALLOC;
                else if (k < 95) op = OP_SET_FREE;
                else op = 3'($urandom_range(int'(OP_RSVD_LO), int'(OP_RSVD_HI)));
                send_request(op, rand_block(nb), rand_count(nb));
                if (n == 125) drain_results();
            end
        end

        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("Ran %0d requests, %0d results, over block counts 0 to 8191.",
                 accepted, results);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
